// ===== hw/rtl/dtl_pkg.sv =====
// Shared types and constants for the decimating trend log.
`timescale 1ns / 1ps
package dtl_pkg;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } dtl_op_t;

  typedef struct packed {
    logic signed [10:0] duty;
    logic signed [15:0] vrms;
    logic        [30:0] freq;
  } dtl_point_t;

  // Store depth and the widths that follow from it.
  localparam int NUM_POINTS  = 256;
  localparam int PT_AW       = $clog2(NUM_POINTS);
  localparam int PT_CW       = PT_AW + 1;
  localparam int OUT_TDATA_W = ((PT_CW + 90 + 7) / 8) * 8;

  localparam logic [30:0] SPAN_LIMIT = 31'h4000_0000;
  localparam logic signed [10:0] DUTY_NONE = -11'sd1;
  localparam int VRMS_HI = 32767;
  localparam int VRMS_LO = -32768;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD,
    ST_DIV_GO,
    ST_DIV,
    ST_STORE,
    ST_CMP_RD0,
    ST_CMP_RD1,
    ST_CMP_WR,
    ST_OUT
  } dtl_state_t;

  // Which bucket average the divider is working on.
  typedef enum logic [1:0] {
    DIV_FREQ,
    DIV_VRMS,
    DIV_DUTY
  } dtl_div_sel_t;

  // Request to the shared divider and its result.
  typedef struct packed {
    logic        start;
    logic        neg;
    logic [63:0] num;
    logic [30:0] den;
  } dtl_div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quo;
  } dtl_div_rsp_t;

endpackage

// ===== hw/rtl/dtl_divider.sv =====
// Restoring divider, one quotient bit per cycle, sign applied at the end.
`timescale 1ns / 1ps
module dtl_divider (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dtl_pkg::dtl_div_req_t req,
  output dtl_pkg::dtl_div_rsp_t rsp
);
  import dtl_pkg::*;

  logic [63:0] quo_r, quo_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [30:0] den_r;
  logic        neg_r;
  logic [6:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [31:0] trial;

  always_comb begin
    trial   = {rem_r[30:0], quo_r[63]};
    rem_nxt = trial;
    quo_nxt = {quo_r[62:0], 1'b0};
    if (trial >= {1'b0, den_r}) begin
      rem_nxt    = trial - {1'b0, den_r};
      quo_nxt[0] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= 7'd64;
        quo_r  <= req.num;
        rem_r  <= '0;
        den_r  <= req.den;
        neg_r  <= req.neg;
      end else if (busy_r) begin
        quo_r <= quo_nxt;
        rem_r <= rem_nxt;
        cnt_r <= cnt_r - 7'd1;
        if (cnt_r == 7'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = neg_r ? (~quo_r + 64'd1) : quo_r;
endmodule

// ===== hw/rtl/dtl_store.sv =====
// Point memory: one write port, one read port with registered data.
`timescale 1ns / 1ps
module dtl_store (
  input  logic                   clk,
  input  logic                   we,
  input  logic [dtl_pkg::PT_AW-1:0] waddr,
  input  dtl_pkg::dtl_point_t    wdata,
  input  logic [dtl_pkg::PT_AW-1:0] raddr,
  output dtl_pkg::dtl_point_t    rdata
);
  import dtl_pkg::*;

  dtl_point_t mem [NUM_POINTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== hw/rtl/decimating_trend_log.sv =====
// Top level of the decimating trend log: bucket sums, sequencer and outputs.
`timescale 1ns / 1ps
// Channel  | Direction | Beat contents (lowest bits first)
// in_      | slave     | tdata: opcode, freq_hz, vrms_mv, duty_tenths, read_index
// out_     | master    | tdata: point_freq, point_vrms, point_duty, point_valid,
//          |           |        stored_count, pushes_per_point
//
// One item is handled at a time. A clear, a no-op or a push that only adds to
// the bucket goes straight to the output state; a read passes ST_RD first.
// A push that closes a bucket runs three divisions (issue, 64 quotient bits,
// capture), then stores the point in ST_STORE before the output state.
// A push that fills the store adds the compaction walk over all 128 pairs,
// each read in ST_CMP_RD0 and ST_CMP_RD1 and written back in ST_CMP_WR.
// Reset (rst_n low, synchronous) empties the log and sets the span to one;
// the point memory is not cleared, entries at or above the count are never reported.
// A stalled output beat holds in its register. The next input beat can still
// be taken, but its result waits in the output state until the register is free.
module decimating_trend_log (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // opcode[1:0], freq_hz[32:2], vrms_mv[53:33], duty_tenths[64:54],
  // read_index[72:65], zero fill to 80 bits
  input  logic [79:0]  in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // point_freq[30:0], point_vrms[46:31], point_duty[57:47], point_valid[58],
  // stored_count[67:59], pushes_per_point[98:68], zero fill to 104 bits
  output logic [dtl_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import dtl_pkg::*;

  localparam int AW = PT_AW;
  localparam int CW = PT_CW;
  localparam int OW = OUT_TDATA_W;
  localparam logic [CW-1:0] FULL = CW'(NUM_POINTS);
  localparam logic [CW-1:0] HALF = CW'(NUM_POINTS / 2);

  dtl_state_t state_r, state_nxt;

  logic [1:0]  opc;
  logic [30:0] f_in;
  logic signed [20:0] v_in;
  logic signed [10:0] d_in;
  logic [7:0]  idx_in;
  assign opc    = in_tdata[1:0];
  assign f_in   = in_tdata[32:2];
  assign v_in   = in_tdata[53:33];
  assign d_in   = in_tdata[64:54];
  assign idx_in = in_tdata[72:65];

  logic          in_acc;

  logic [CW-1:0] count_r;
  logic [30:0]   span_r;
  logic [30:0]   bpush_r;
  logic [63:0]   fsum_r;
  logic signed [63:0] vsum_r;
  logic [41:0]   dsum_r;
  logic [30:0]   dcnt_r;
  logic [7:0]    idx_r;
  logic          rdok_r;

  dtl_div_sel_t divsel_r;
  logic [30:0] pf_r;
  logic signed [63:0] vq_r;
  logic signed [15:0] pv_sat;
  logic signed [10:0] pd_r;

  logic [AW-1:0] pair_r;
  dtl_point_t    a_r;

  dtl_div_req_t dreq;
  dtl_div_rsp_t drsp;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  dtl_point_t    wdata, rdata;

  logic [OW-1:0] obuf_r;
  logic          ovalid_r;

  dtl_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  dtl_store u_store (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  // The output register parts the two sides: input is taken whenever idle.
  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = ovalid_r;
  assign out_tdata  = obuf_r;

  // Compaction arithmetic on the pair a_r / rdata.
  logic [31:0] cf_sum;
  logic signed [16:0] cv_sum;
  logic signed [11:0] cd_sum;
  dtl_point_t cmp_pt;
  always_comb begin
    cf_sum = {1'b0, a_r.freq} + {1'b0, rdata.freq};
    cv_sum = 17'(a_r.vrms) + 17'(rdata.vrms);
    cd_sum = 12'(a_r.duty) + 12'(rdata.duty);
    cmp_pt.freq = cf_sum[31:1];
    // Adding the sign bit before the shift rounds odd negative sums toward zero.
    cmp_pt.vrms = 16'((cv_sum + 17'(cv_sum[16])) >>> 1);
    if (!a_r.duty[10] && !rdata.duty[10]) begin
      cmp_pt.duty = 11'(cd_sum >>> 1);
    end else if (!a_r.duty[10]) begin
      cmp_pt.duty = a_r.duty;
    end else begin
      cmp_pt.duty = rdata.duty;
    end
  end

  // Clamp the voltage average to the 16-bit point field.
  always_comb begin
    if (vq_r > 64'(VRMS_HI)) begin
      pv_sat = 16'(VRMS_HI);
    end else if (vq_r < 64'(VRMS_LO)) begin
      pv_sat = 16'(VRMS_LO);
    end else begin
      pv_sat = vq_r[15:0];
    end
  end

  logic [30:0] bp_inc;
  assign bp_inc = bpush_r + 31'd1;

  // Sequencer.
  always_comb begin
    state_nxt  = state_r;
    dreq       = '0;
    we         = 1'b0;
    waddr      = count_r[AW-1:0];
    wdata      = '{duty: pd_r, vrms: pv_sat, freq: pf_r};
    raddr      = idx_r[AW-1:0];
    case (state_r)
      ST_IDLE: begin
        // A read gets its entry on the accepting edge.
        raddr = idx_in[AW-1:0];
        if (in_acc) begin
          case (opc)
            OP_PUSH: state_nxt = (bp_inc >= span_r) ? ST_DIV_GO : ST_OUT;
            OP_READ: state_nxt = ST_RD;
            default: state_nxt = ST_OUT;
          endcase
        end
      end
      ST_RD:  state_nxt = ST_OUT;
      ST_DIV_GO: begin
        dreq.start = 1'b1;
        case (divsel_r)
          DIV_FREQ: begin
            dreq.num = fsum_r;
            dreq.den = bpush_r;
          end
          DIV_VRMS: begin
            dreq.neg = vsum_r[63];
            dreq.num = vsum_r[63] ? 64'(-vsum_r) : 64'(vsum_r);
            dreq.den = bpush_r;
          end
          default: begin
            if (dcnt_r == '0) begin
              dreq.num = '0;
              dreq.den = 31'd1;
            end else begin
              dreq.num = 64'(dsum_r);
              dreq.den = dcnt_r;
            end
          end
        endcase
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (drsp.done) begin
          state_nxt = (divsel_r == DIV_DUTY) ? ST_STORE : ST_DIV_GO;
        end
      end
      ST_STORE: begin
        we = 1'b1;
        if (count_r + CW'(1) >= FULL) begin
          state_nxt = ST_CMP_RD0;
        end else begin
          state_nxt = ST_OUT;
        end
      end
      ST_CMP_RD0: begin
        raddr     = {pair_r[AW-2:0], 1'b0};
        state_nxt = ST_CMP_RD1;
      end
      ST_CMP_RD1: begin
        raddr     = {pair_r[AW-2:0], 1'b1};
        state_nxt = ST_CMP_WR;
      end
      ST_CMP_WR: begin
        // Pair p lands at p, never above an entry still to be read.
        we    = 1'b1;
        waddr = pair_r;
        wdata = cmp_pt;
        state_nxt = (pair_r == AW'(NUM_POINTS / 2 - 1)) ? ST_OUT : ST_CMP_RD0;
      end
      ST_OUT: begin
        if (!ovalid_r || out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      count_r  <= '0;
      span_r   <= 31'd1;
      bpush_r  <= '0;
      fsum_r   <= '0;
      vsum_r   <= '0;
      dsum_r   <= '0;
      dcnt_r   <= '0;
      ovalid_r <= 1'b0;
      rdok_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if ((state_r == ST_OUT) && (!ovalid_r || out_tready)) begin
        ovalid_r <= 1'b1;
        obuf_r   <= OW'({span_r, count_r, rdok_r,
                         rdok_r ? rdata.duty : DUTY_NONE,
                         rdok_r ? rdata.vrms : 16'sd0,
                         rdok_r ? rdata.freq : 31'd0});
      end else if (out_tready) begin
        ovalid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            idx_r  <= idx_in;
            rdok_r <= (opc == OP_READ) && (CW'(idx_in) < count_r);
            case (opc)
              OP_PUSH: begin
                fsum_r  <= fsum_r + 64'(f_in);
                vsum_r  <= vsum_r + 64'(v_in);
                if (!d_in[10]) begin
                  dsum_r <= dsum_r + 42'(d_in);
                  dcnt_r <= dcnt_r + 31'd1;
                end
                bpush_r  <= bp_inc;
                divsel_r <= DIV_FREQ;
              end
              OP_CLEAR: begin
                count_r <= '0;
                span_r  <= 31'd1;
                bpush_r <= '0;
                fsum_r  <= '0;
                vsum_r  <= '0;
                dsum_r  <= '0;
                dcnt_r  <= '0;
              end
              default: ;
            endcase
          end
        end
        ST_DIV: begin
          if (drsp.done) begin
            case (divsel_r)
              DIV_FREQ: begin
                pf_r     <= drsp.quo[30:0];
                divsel_r <= DIV_VRMS;
              end
              DIV_VRMS: begin
                vq_r     <= drsp.quo;
                divsel_r <= DIV_DUTY;
              end
              default: pd_r <= (dcnt_r == '0) ? DUTY_NONE : 11'(drsp.quo);
            endcase
          end
        end
        ST_STORE: begin
          count_r <= count_r + CW'(1);
          bpush_r <= '0;
          fsum_r  <= '0;
          vsum_r  <= '0;
          dsum_r  <= '0;
          dcnt_r  <= '0;
          pair_r  <= '0;
        end
        ST_CMP_RD1: a_r <= rdata;
        ST_CMP_WR: begin
          pair_r <= pair_r + AW'(1);
          if (pair_r == AW'(NUM_POINTS / 2 - 1)) begin
            count_r <= HALF;
            span_r  <= (span_r >= (SPAN_LIMIT >> 1)) ? SPAN_LIMIT : (span_r << 1);
          end
        end
        default: ;
      endcase
    end
  end
endmodule

// ===== test/tb_decimating_trend_log.sv =====
// Self-checking testbench for the decimating trend log stream block.
`timescale 1ns / 1ps
module tb_decimating_trend_log;
  import dtl_pkg::*;

  localparam int NPTS = 256;
  localparam int CNT_W = 9;
  localparam int OUT_W = ((CNT_W + 90 + 7) / 8) * 8;

  typedef struct packed {
    logic [1:0] opcode;
    logic [30:0] freq_hz;
    logic [20:0] vrms_mv;
    logic [10:0] duty_tenths;
    logic [7:0] read_index;
  } log_cmd_t;

  typedef struct packed {
    logic [30:0] freq;
    logic [15:0] vrms;
    logic [10:0] duty;
    logic valid;
    logic [8:0] count;
    logic [30:0] span;
  } log_report_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [79:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;

  decimating_trend_log uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow of the log state.
  int signed sh_freq [NPTS];
  int signed sh_vrms [NPTS];
  int signed sh_duty [NPTS];
  int unsigned sh_count = 0;
  longint unsigned sh_span = 1;
  longint unsigned sh_pushes = 0;
  longint unsigned sh_fsum = 0;
  longint signed sh_vsum = 0;
  longint signed sh_dsum = 0;
  longint signed sh_dcnt = 0;

  log_cmd_t cmd_q[$];
  log_report_t report_q[$];
  int errors = 0;
  int accepted = 0;

  function automatic void empty_bucket();
    sh_pushes = 0; sh_fsum = 0; sh_vsum = 0; sh_dsum = 0; sh_dcnt = 0;
  endfunction

  // Average neighboring pairs in place, halve the count, double the span up to 2^30.
  function automatic void halve_log();
    int signed a, b;
    for (int i = 0; i < NPTS / 2; i++) begin
      sh_freq[i] = int'((longint'(sh_freq[2*i]) + longint'(sh_freq[2*i+1])) / 2);
      sh_vrms[i] = (sh_vrms[2*i] + sh_vrms[2*i+1]) / 2;
      a = sh_duty[2*i];
      b = sh_duty[2*i+1];
      if (a >= 0 && b >= 0) sh_duty[i] = (a + b) / 2;
      else if (a >= 0) sh_duty[i] = a;
      else sh_duty[i] = b;
    end
    sh_count = NPTS / 2;
    sh_span = (sh_span >= 64'd536870912) ? 64'd1073741824 : sh_span * 2;
  endfunction

  function automatic void add_sample(log_cmd_t c);
    longint signed v, d, avg;
    v = longint'($signed(c.vrms_mv));
    d = longint'($signed(c.duty_tenths));
    sh_fsum += longint'(c.freq_hz);
    sh_vsum += v;
    if (d >= 0) begin
      sh_dsum += d;
      sh_dcnt++;
    end
    sh_pushes++;
    if (sh_pushes < sh_span) return;
    sh_freq[sh_count] = int'((sh_fsum / sh_pushes) & 64'h7FFF_FFFF);
    avg = sh_vsum / longint'(sh_pushes);
    if (avg > VRMS_HI) avg = VRMS_HI;
    if (avg < VRMS_LO) avg = VRMS_LO;
    sh_vrms[sh_count] = int'(avg);
    sh_duty[sh_count] = (sh_dcnt != 0) ? int'(sh_dsum / sh_dcnt) : -1;
    sh_count++;
    empty_bucket();
    if (sh_count >= NPTS) halve_log();
  endfunction

  function automatic log_report_t predict_report(log_cmd_t c);
    log_report_t r;
    r = '0;
    r.duty = DUTY_NONE;
    case (dtl_op_t'(c.opcode))
      OP_PUSH: add_sample(c);
      OP_READ: begin
        if (c.read_index < sh_count) begin
          r.freq = sh_freq[c.read_index][30:0];
          r.vrms = sh_vrms[c.read_index][15:0];
          r.duty = sh_duty[c.read_index][10:0];
          r.valid = 1'b1;
        end
      end
      OP_CLEAR: begin
        sh_count = 0;
        sh_span = 1;
        empty_bucket();
      end
      default: ;
    endcase
    r.count = sh_count[8:0];
    r.span = sh_span[30:0];
    return r;
  endfunction

  function automatic log_cmd_t make_cmd(dtl_op_t op, logic [30:0] f, logic [20:0] v,
                                        logic [10:0] d, logic [7:0] idx);
    log_cmd_t c;
    c.opcode = op; c.freq_hz = f; c.vrms_mv = v; c.duty_tenths = d; c.read_index = idx;
    return c;
  endfunction

  // Command whose unused fields carry random bits.
  function automatic log_cmd_t noise_cmd(dtl_op_t op);
    return make_cmd(op, 31'($urandom), 21'($urandom), 11'($urandom), 8'($urandom));
  endfunction

  function automatic log_cmd_t random_cmd();
    int sel;
    logic [30:0] f;
    logic [20:0] v;
    logic [10:0] d;
    sel = $urandom_range(0, 999);
    f = ($urandom_range(0, 3) == 0) ? 31'($urandom) : 31'($urandom_range(45, 65));
    case ($urandom_range(0, 3))
      0: v = 21'($urandom);
      1: v = 21'($urandom_range(0, 2000000) - 1000000);
      default: v = 21'($urandom_range(0, 60000) - 30000);
    endcase
    case ($urandom_range(0, 4))
      0: d = -11'sd1;
      1: d = 11'($urandom);
      default: d = 11'($urandom_range(0, 1000));
    endcase
    if (sel < 700) return make_cmd(OP_PUSH, f, v, d, '0);
    if (sel < 960) return noise_cmd(OP_READ);
    if (sel < 997) return noise_cmd(OP_NOP);
    return noise_cmd(OP_CLEAR);
  endfunction

  // Input side: bursts of beats separated by random gaps.
  logic offered = 1'b0;
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      report_q.push_back(predict_report(cmd_q.pop_front()));
      offered <= 1'b0;
      accepted++;
    end
  end

  always @(negedge clk) begin
    if (rst_n && !offered) begin
      if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (cmd_q.size() > 0) begin
        in_tdata <= {7'd0, cmd_q[0].read_index, cmd_q[0].duty_tenths, cmd_q[0].vrms_mv,
                     cmd_q[0].freq_hz, cmd_q[0].opcode};
        in_tvalid <= 1'b1;
        offered <= 1'b1;
        if (burst_left > 0) burst_left--;
        else begin
          burst_left = $urandom_range(0, 12);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Output side: random stalls, with one long hold-off partway through.
  int hold_left = 0;
  bit held = 1'b0;

  always @(negedge clk) begin
    if (rst_n) begin
      if (!held && accepted >= 300) begin
        held = 1'b1;
        hold_left = 2000;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ((accepted / 64) % 3 == 0) ? 1'b1 : ($urandom_range(0, 3) != 0);
      end
    end
  end

  // Result checker.
  always @(posedge clk) begin
    log_report_t got, exp;
    if (rst_n && out_tvalid && out_tready) begin
      got.freq = out_tdata[30:0];
      got.vrms = out_tdata[46:31];
      got.duty = out_tdata[57:47];
      got.valid = out_tdata[58];
      got.count = out_tdata[CNT_W+58:59];
      got.span = out_tdata[CNT_W+89:CNT_W+59];
      if (report_q.size() == 0) begin
        $error("unexpected result beat %h", out_tdata);
        errors++;
      end else begin
        exp = report_q.pop_front();
        if (got.freq !== exp.freq) begin
          $error("point_freq expected %0d got %0d", exp.freq, got.freq); errors++;
        end
        if (got.vrms !== exp.vrms) begin
          $error("point_vrms expected %0d got %0d", $signed(exp.vrms), $signed(got.vrms));
          errors++;
        end
        if (got.duty !== exp.duty) begin
          $error("point_duty expected %0d got %0d", $signed(exp.duty), $signed(got.duty));
          errors++;
        end
        if (got.valid !== exp.valid) begin
          $error("point_valid expected %0d got %0d", exp.valid, got.valid); errors++;
        end
        if (got.count !== exp.count) begin
          $error("stored_count expected %0d got %0d", exp.count, got.count); errors++;
        end
        if (got.span !== exp.span) begin
          $error("pushes_per_point expected %0d got %0d", exp.span, got.span); errors++;
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    // Directed: empty reads, nop, field extremes, absent and odd duties, clear.
    cmd_q.push_back(make_cmd(OP_READ, '0, '0, '0, 8'd0));
    cmd_q.push_back(make_cmd(OP_NOP, '1, '1, '1, '1));
    cmd_q.push_back(make_cmd(OP_PUSH, 31'h7FFF_FFFF, 21'sd1000000, 11'sd1000, '0));
    cmd_q.push_back(make_cmd(OP_PUSH, '0, -21'sd1000000, -11'sd1, '1));
    cmd_q.push_back(make_cmd(OP_PUSH, 31'd50, 21'h0F_FFFF, 11'h3FF, '0));
    cmd_q.push_back(make_cmd(OP_PUSH, 31'd60, 21'h10_0000, 11'h400, '0));
    cmd_q.push_back(make_cmd(OP_PUSH, 31'd1, 21'sd32767, -11'sd7, '0));
    cmd_q.push_back(make_cmd(OP_PUSH, 31'd2, -21'sd32768, 11'sd0, '0));
    cmd_q.push_back(make_cmd(OP_PUSH, 31'd3, -21'sd5, 11'sd1, '0));
    for (int i = 0; i < 8; i++) cmd_q.push_back(make_cmd(OP_READ, '0, '0, '0, 8'(i)));
    cmd_q.push_back(make_cmd(OP_READ, '0, '0, '0, 8'd255));
    cmd_q.push_back(make_cmd(OP_CLEAR, '0, '0, '0, '0));
    cmd_q.push_back(make_cmd(OP_READ, '0, '0, '0, 8'd0));
    for (int i = 0; i < 900; i++) cmd_q.push_back(random_cmd());
    wait (cmd_q.size() == 0 && report_q.size() == 0 && !offered);
    repeat (1000) @(posedge clk);
    if (errors == 0 && report_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/dtl_pkg.sv
hw/rtl/dtl_divider.sv
hw/rtl/dtl_store.sv
hw/rtl/decimating_trend_log.sv
test/tb_decimating_trend_log.sv
